@@ rtl/set_assoc_lru_cache_sim_assert.svh @@
// Assertion macros for the cache simulator checker
`ifndef SET_ASSOC_LRU_CACHE_SIM_ASSERT_SVH
`define SET_ASSOC_LRU_CACHE_SIM_ASSERT_SVH

// a |-> b, reset-qualified
`define SLC_ASSERT_IMP(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");

// a |=> b, reset-qualified
`define SLC_ASSERT_NXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");

`endif

@@ rtl/slc_pkg.sv @@
// ----------------------------------------------------------------------------
// slc_pkg
// Types and constants shared by the cache simulator modules.
// ----------------------------------------------------------------------------
`default_nettype none
package slc_pkg;
  localparam int unsigned MaxSets  = 256;
  localparam int unsigned MaxWays  = 8;
  localparam int unsigned SetW     = $clog2(MaxSets);
  localparam int unsigned WayW     = $clog2(MaxWays);
  localparam int unsigned RankW    = 3;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 5;

  localparam logic [CfgIdxW-1:0] CfgSetBits   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgBlockBits = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgWaysUsed  = 2'd2;

  localparam logic [1:0] OpModify = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] address;
  } req_t;

  typedef struct packed {
    logic        was_hit;
    logic        was_miss;
    logic        was_eviction;
    logic [1:0]  hit_count;
    logic [31:0] total_hits;
    logic [31:0] total_misses;
    logic [31:0] total_evictions;
  } rsp_t;

  typedef struct packed {
    logic load_req;  // latch request, issue set read
    logic update;    // write back set, bump totals, present result
    logic clr_step;  // clear one set of valid bits
  } ctl_cmd_t;

  typedef struct packed {
    logic clr_done;
  } ctl_sts_t;
endpackage
`default_nettype wire

@@ rtl/slc_ctrl.sv @@
// ----------------------------------------------------------------------------
// slc_ctrl
// Sequencer: clearing pass after reset, then read / update per access.
// ----------------------------------------------------------------------------
`default_nettype none
module slc_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start_i,
  input  slc_pkg::ctl_sts_t   sts_i,
  output slc_pkg::ctl_cmd_t   cmd_o,
  output logic                busy_o
);
  import slc_pkg::*;

  typedef enum logic [1:0] {StClear, StIdle, StUpdate} state_e;
  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StClear: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) state_d = StIdle;
      end
      StIdle: begin
        if (start_i) begin
          cmd_o.load_req = 1'b1;
          state_d = StUpdate;
        end
      end
      StUpdate: begin
        cmd_o.update = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StClear;
    endcase
  end

  assign busy_o = (state_q != StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
    end else begin
      state_q <= state_d;
    end
  end
endmodule
`default_nettype wire

@@ rtl/slc_dpath.sv @@
// ----------------------------------------------------------------------------
// slc_dpath
// Tag / rank memory per set, valid bits, way compare, LRU update, totals.
// ----------------------------------------------------------------------------
`default_nettype none
module slc_dpath (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  slc_pkg::ctl_cmd_t            cmd_i,
  output slc_pkg::ctl_sts_t            sts_o,
  input  wire                          cfg_we_i,
  input  wire [slc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire [slc_pkg::CfgDataW-1:0]  cfg_data_i,
  input  slc_pkg::req_t                req_i,
  output logic                         done_o,
  output slc_pkg::rsp_t                rsp_o
);
  import slc_pkg::*;

  typedef logic [MaxWays-1:0][63:0]      tags_t;
  typedef logic [MaxWays-1:0][RankW-1:0] ranks_t;

  // memories: one row per set
  tags_t  tag_mem  [MaxSets];
  ranks_t rank_mem [MaxSets];
  logic [MaxWays-1:0] vld_mem [MaxSets];

  logic [3:0] set_bits_q;
  logic [4:0] block_bits_q;
  logic [3:0] ways_q;

  logic [1:0]        op_q;
  logic [63:0]       blk_q;
  logic [SetW-1:0]   set_q;
  logic [SetW:0]     clr_cnt_q;
  tags_t             tags_rd_q;
  ranks_t            ranks_rd_q;
  logic [MaxWays-1:0] vld_rd_q;
  logic [31:0] hits_q, miss_q, evict_q;
  logic        done_q;
  rsp_t        rsp_q;

  // request decode
  logic [63:0]     blk_d;
  logic [3:0]      sb_eff;
  logic [SetW-1:0] set_d;
  assign blk_d  = req_i.address >> block_bits_q;
  assign sb_eff = (set_bits_q > 4'(SetW)) ? 4'(SetW) : set_bits_q;
  assign set_d  = SetW'(blk_d & ((64'd1 << sb_eff) - 64'd1));

  // effective ways
  logic [4:0] ways_eff;
  assign ways_eff = (ways_q == 4'd0) ? 5'd1 :
                    (ways_q > 4'(MaxWays)) ? 5'(MaxWays) : {1'b0, ways_q};

  // per-way lookup
  logic [MaxWays-1:0] in_use, live, match;
  always_comb begin
    for (int w = 0; w < MaxWays; w++) begin
      in_use[w] = (5'(w) < ways_eff);
      live[w]   = in_use[w] & vld_rd_q[w];
      match[w]  = live[w] & (tags_rd_q[w] == blk_q);
    end
  end

  logic           hit, have_free;
  logic [WayW-1:0] hit_way, free_way, victim, target;
  logic [RankW:0]  best;
  always_comb begin
    hit = 1'b0; have_free = 1'b0;
    hit_way = '0; free_way = '0; victim = '0;
    best = '1;  // -1 marker: top bit set means none
    for (int w = 0; w < MaxWays; w++) begin
      if (in_use[w] && !vld_rd_q[w] && !have_free) begin
        have_free = 1'b1;
        free_way  = WayW'(w);
      end
      if (match[w]) begin
        hit = 1'b1;
        hit_way = WayW'(w);
      end
      if (live[w] && (best[RankW] || {1'b0, ranks_rd_q[w]} > best)) begin
        best   = {1'b0, ranks_rd_q[w]};
        victim = WayW'(w);
      end
    end
    target = hit ? hit_way : (have_free ? free_way : victim);
  end

  logic   evict;
  logic [RankW:0] old_rank;
  ranks_t ranks_new;
  tags_t  tags_new;
  logic [MaxWays-1:0] vld_new;
  assign evict    = !hit && !have_free;
  assign old_rank = vld_rd_q[target] ? {1'b0, ranks_rd_q[target]} : '1;
  always_comb begin
    ranks_new = ranks_rd_q;
    tags_new  = tags_rd_q;
    vld_new   = vld_rd_q;
    for (int w = 0; w < MaxWays; w++) begin
      if (WayW'(w) == target) begin
        ranks_new[w] = '0;
      end else if (live[w] && ({1'b0, ranks_rd_q[w]} < old_rank) &&
                   (ranks_rd_q[w] != RankW'(MaxWays-1))) begin
        ranks_new[w] = ranks_rd_q[w] + 1'b1;
      end
    end
    tags_new[target] = blk_q;
    vld_new[target]  = 1'b1;
  end

  logic [1:0] hcount;
  assign hcount = {1'b0, hit} + ((op_q == OpModify) ? 2'd1 : 2'd0);

  function automatic logic [31:0] sat_add(logic [31:0] a, logic [1:0] b);
    logic [32:0] s;
    s = {1'b0, a} + 33'(b);
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  logic [31:0] hits_d, miss_d, evict_d;
  assign hits_d  = sat_add(hits_q, hcount);
  assign miss_d  = sat_add(miss_q, {1'b0, !hit});
  assign evict_d = sat_add(evict_q, {1'b0, evict});

  assign sts_o.clr_done = (clr_cnt_q == (SetW+1)'(MaxSets-1)) || clr_cnt_q[SetW];

  // memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      tags_rd_q  <= tag_mem[set_d];
      ranks_rd_q <= rank_mem[set_d];
      vld_rd_q   <= vld_mem[set_d];
      op_q       <= req_i.op;
      blk_q      <= blk_d;
      set_q      <= set_d;
    end
    if (cmd_i.update) begin
      tag_mem[set_q]  <= tags_new;
      rank_mem[set_q] <= ranks_new;
      vld_mem[set_q]  <= vld_new;
    end else if (cmd_i.clr_step) begin
      vld_mem[clr_cnt_q[SetW-1:0]] <= '0;
    end
    rsp_q <= '{was_hit: hit, was_miss: !hit, was_eviction: evict,
               hit_count: hcount, total_hits: hits_d,
               total_misses: miss_d, total_evictions: evict_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q   <= 4'd4;
      block_bits_q <= 5'd4;
      ways_q       <= 4'd1;
      clr_cnt_q    <= '0;
      hits_q <= '0; miss_q <= '0; evict_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.update;
      if (cmd_i.clr_step) clr_cnt_q <= clr_cnt_q + 1'b1;
      if (cmd_i.update) begin
        hits_q <= hits_d; miss_q <= miss_d; evict_q <= evict_d;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgSetBits:   set_bits_q   <= cfg_data_i[3:0];
          CfgBlockBits: block_bits_q <= cfg_data_i;
          CfgWaysUsed:  ways_q       <= cfg_data_i[3:0];
          default: ;
        endcase
      end
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;
endmodule
`default_nettype wire

@@ rtl/set_assoc_lru_cache_sim.sv @@
// The result is presented on done_o/rsp_o after the set read, then the update into the output reg.
// busy is high for the one update cycle after each start beat; no new access is taken during it.
// Reset: a clearing pass over all 256 set rows (one set row a cycle) holds busy high.
// Config writes are taken at any time, including during the clearing pass.
// Results cannot be stalled: done_o is a one-cycle strobe.
`default_nettype none
module set_assoc_lru_cache_sim (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start,
  output logic                         busy,
  input  slc_pkg::req_t                req_i,
  output logic                         done_o,
  output slc_pkg::rsp_t                rsp_o,
  input  wire                          cfg_we_i,
  input  wire [slc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire [slc_pkg::CfgDataW-1:0]  cfg_data_i
);
  import slc_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  slc_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .sts_i(sts), .cmd_o(cmd), .busy_o(busy)
  );

  slc_dpath u_dpath (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .cfg_we_i, .cfg_idx_i,
    .cfg_data_i, .req_i, .done_o, .rsp_o
  );
endmodule
`default_nettype wire

@@ rtl/slc_checker.sv @@
// ----------------------------------------------------------------------------
// slc_port_checker
// Port-level checks on the cache simulator.
// ----------------------------------------------------------------------------
`default_nettype none
`include "set_assoc_lru_cache_sim_assert.svh"
module slc_port_checker (
  input wire            clk_i,
  input wire            rst_ni,
  input wire            start,
  input wire            busy,
  input wire            done_o,
  input slc_pkg::rsp_t  rsp_o
);
  import slc_pkg::*;

  `SLC_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy)
  `SLC_ASSERT_IMP(a_hit_xor_miss, clk_i, rst_ni, done_o, rsp_o.was_hit != rsp_o.was_miss)
  `SLC_ASSERT_IMP(a_evict_miss, clk_i, rst_ni, done_o && rsp_o.was_eviction, rsp_o.was_miss)
  `SLC_ASSERT_NXT(a_done_single, clk_i, rst_ni, done_o, !done_o)
endmodule

bind set_assoc_lru_cache_sim slc_port_checker u_slc_checker (
  .clk_i, .rst_ni, .start, .busy, .done_o, .rsp_o
);
`default_nettype wire
